// ----- rtl/lsht_pkg.sv -----
// Shared types and constants for the thick line segment hit test.
// Holds coordinate widths, payload structs, register indexes and region codes.
// Depends on nothing; every other file in rtl/ uses it by scoped names.
`default_nettype none

package lsht_pkg;

  // Coordinate and width formats (signed Q12.4, unsigned Q8.4)
  localparam int COORD_WIDTH = 16;
  localparam int LW_WIDTH    = 12;

  // Derived datapath widths
  localparam int DIFF_WIDTH    = COORD_WIDTH + 1;
  localparam int PROD_WIDTH    = 2 * DIFF_WIDTH;
  localparam int SUM_WIDTH     = PROD_WIDTH + 1;
  localparam int SQ_WIDTH      = 2 * COORD_WIDTH + 2;
  localparam int HALF_WIDTH    = SQ_WIDTH / 2;
  localparam int W2_WIDTH      = 2 * LW_WIDTH;
  localparam int CMP_WIDTH     = 2 * SQ_WIDTH + W2_WIDTH;
  localparam int RECT_WIDTH    = COORD_WIDTH + LW_WIDTH + 2;
  localparam int CFG_IDX_WIDTH = 3;
  localparam int REGION_WIDTH  = 3;

  // Configuration register indexes
  localparam logic [CFG_IDX_WIDTH-1:0] CFG_START_X    = 3'd0;
  localparam logic [CFG_IDX_WIDTH-1:0] CFG_START_Y    = 3'd1;
  localparam logic [CFG_IDX_WIDTH-1:0] CFG_END_X      = 3'd2;
  localparam logic [CFG_IDX_WIDTH-1:0] CFG_END_Y      = 3'd3;
  localparam logic [CFG_IDX_WIDTH-1:0] CFG_LINE_WIDTH = 3'd4;

  // Reset value of the line width (5.0 px)
  localparam logic [LW_WIDTH-1:0] LINE_WIDTH_RST = 12'd80;

  // Region codes reported with each result
  localparam logic [REGION_WIDTH-1:0] REGION_HORZ     = 3'd0;
  localparam logic [REGION_WIDTH-1:0] REGION_VERT     = 3'd1;
  localparam logic [REGION_WIDTH-1:0] REGION_START    = 3'd2;
  localparam logic [REGION_WIDTH-1:0] REGION_END      = 3'd3;
  localparam logic [REGION_WIDTH-1:0] REGION_INTERIOR = 3'd4;

  // Segment shape chosen from the endpoints
  typedef enum logic [1:0] {
    MODE_HORZ,
    MODE_VERT,
    MODE_DIST
  } mode_t;

  typedef struct packed {
    logic signed [COORD_WIDTH-1:0] point_x;
    logic signed [COORD_WIDTH-1:0] point_y;
  } in_t;

  typedef struct packed {
    logic                    hit;
    logic [REGION_WIDTH-1:0] region;
  } out_t;

  typedef struct packed {
    logic signed [COORD_WIDTH-1:0] start_x;
    logic signed [COORD_WIDTH-1:0] start_y;
    logic signed [COORD_WIDTH-1:0] end_x;
    logic signed [COORD_WIDTH-1:0] end_y;
    logic [LW_WIDTH-1:0]           line_width;
  } cfg_t;

  // Control that travels alongside the datapath between stage modules
  typedef struct packed {
    logic  valid;
    mode_t mode;
    logic  rect_hit;
  } ctl_t;

endpackage

`default_nettype wire

// ----- rtl/lsht_diff.sv -----
// First pipeline stage: offsets of the point from both endpoints, shape
// selection and the complete open-rectangle test for axis-aligned segments.
// Depends on lsht_pkg.
`default_nettype none

module lsht_diff (
  input  wire logic                                  clk,
  input  wire logic                                  rst_n,
  input  wire logic                                  accept,
  input  wire lsht_pkg::in_t                         in_data,
  input  wire lsht_pkg::cfg_t                        cfg,
  output lsht_pkg::ctl_t                             ctl,
  output logic signed [lsht_pkg::DIFF_WIDTH-1:0]     ax,
  output logic signed [lsht_pkg::DIFF_WIDTH-1:0]     ay,
  output logic signed [lsht_pkg::DIFF_WIDTH-1:0]     bx,
  output logic signed [lsht_pkg::DIFF_WIDTH-1:0]     by
);

  localparam int CW = lsht_pkg::COORD_WIDTH;
  localparam int DW = lsht_pkg::DIFF_WIDTH;
  localparam int RW = lsht_pkg::RECT_WIDTH;

  logic signed [CW-1:0] px, py, sx, sy, ex, ey;
  logic signed [DW-1:0] px_e, py_e, sx_e, sy_e, ex_e, ey_e;
  logic signed [RW-1:0] x2, y2, sx2, sy2, ex2, ey2, wd;
  logic                 fwd;
  logic                 rect_nxt;
  lsht_pkg::mode_t      mode_nxt;

  logic                 valid_r;
  lsht_pkg::mode_t      mode_r;
  logic                 rect_r;
  logic signed [DW-1:0] ax_r, ay_r, bx_r, by_r;

  assign px = in_data.point_x;
  assign py = in_data.point_y;
  assign sx = cfg.start_x;
  assign sy = cfg.start_y;
  assign ex = cfg.end_x;
  assign ey = cfg.end_y;

  // Sign-extend by one bit for the offsets
  assign px_e = {px[CW-1], px};
  assign py_e = {py[CW-1], py};
  assign sx_e = {sx[CW-1], sx};
  assign sy_e = {sy[CW-1], sy};
  assign ex_e = {ex[CW-1], ex};
  assign ey_e = {ey[CW-1], ey};

  // Doubled coordinates so that half the width stays exact
  assign x2  = {{(RW-CW-1){px[CW-1]}}, px, 1'b0};
  assign y2  = {{(RW-CW-1){py[CW-1]}}, py, 1'b0};
  assign sx2 = {{(RW-CW-1){sx[CW-1]}}, sx, 1'b0};
  assign sy2 = {{(RW-CW-1){sy[CW-1]}}, sy, 1'b0};
  assign ex2 = {{(RW-CW-1){ex[CW-1]}}, ex, 1'b0};
  assign ey2 = {{(RW-CW-1){ey[CW-1]}}, ey, 1'b0};
  assign wd  = {{(RW-lsht_pkg::LW_WIDTH){1'b0}}, cfg.line_width};

  // Pick the shape: shared y first, then shared x, else distance test
  always_comb begin
    if (sy == ey) begin
      mode_nxt = lsht_pkg::MODE_HORZ;
      fwd      = (sx < ex);
    end else if (sx == ex) begin
      mode_nxt = lsht_pkg::MODE_VERT;
      fwd      = (sy < ey);
    end else begin
      mode_nxt = lsht_pkg::MODE_DIST;
      fwd      = 1'b0;
    end
  end

  // Open rectangle widened by half the width on every side
  always_comb begin
    if (fwd) begin
      rect_nxt = (x2 > sx2 - wd) && (y2 > sy2 - wd) && (x2 < ex2 + wd) && (y2 < ey2 + wd);
    end else begin
      rect_nxt = (x2 < sx2 + wd) && (y2 < sy2 + wd) && (x2 > ex2 - wd) && (y2 > ey2 - wd);
    end
  end

  // Advance the valid bit
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= accept;
    end
  end

  // Capture the stage payload
  always_ff @(posedge clk) begin
    mode_r <= mode_nxt;
    rect_r <= rect_nxt;
    ax_r   <= px_e - sx_e;
    ay_r   <= py_e - sy_e;
    bx_r   <= px_e - ex_e;
    by_r   <= py_e - ey_e;
  end

  assign ctl = '{valid: valid_r, mode: mode_r, rect_hit: rect_r};
  assign ax  = ax_r;
  assign ay  = ay_r;
  assign bx  = bx_r;
  assign by  = by_r;

endmodule

`default_nettype wire

// ----- rtl/lsht_mult.sv -----
// Second and third pipeline stages: all signed products of the offsets and
// the segment direction, then the dot, cross and squared-length sums.
// Depends on lsht_pkg.
`default_nettype none

module lsht_mult (
  input  wire logic                                   clk,
  input  wire logic                                   rst_n,
  input  wire lsht_pkg::ctl_t                         ctl_i,
  input  wire logic signed [lsht_pkg::DIFF_WIDTH-1:0] ax,
  input  wire logic signed [lsht_pkg::DIFF_WIDTH-1:0] ay,
  input  wire logic signed [lsht_pkg::DIFF_WIDTH-1:0] bx,
  input  wire logic signed [lsht_pkg::DIFF_WIDTH-1:0] by,
  input  wire lsht_pkg::cfg_t                         cfg,
  output lsht_pkg::ctl_t                              ctl_o,
  output logic signed [lsht_pkg::SUM_WIDTH-1:0]       dot,
  output logic signed [lsht_pkg::SUM_WIDTH-1:0]       cp,
  output logic [lsht_pkg::SQ_WIDTH-1:0]               near_sq,
  output logic [lsht_pkg::SQ_WIDTH-1:0]               far_sq,
  output logic [lsht_pkg::SQ_WIDTH-1:0]               d2
);

  localparam int CW = lsht_pkg::COORD_WIDTH;
  localparam int DW = lsht_pkg::DIFF_WIDTH;
  localparam int PW = lsht_pkg::PROD_WIDTH;
  localparam int SW = lsht_pkg::SUM_WIDTH;
  localparam int QW = lsht_pkg::SQ_WIDTH;

  logic signed [CW-1:0] sx, sy, ex, ey;
  logic signed [DW-1:0] dx, dy;

  // Product stage
  logic signed [PW-1:0] dxax_nxt, dyay_nxt, dxay_nxt, dyax_nxt;
  logic signed [PW-1:0] sqax_nxt, sqay_nxt, sqbx_nxt, sqby_nxt, sqdx_nxt, sqdy_nxt;
  lsht_pkg::ctl_t       ctl_b_r;
  logic signed [PW-1:0] dxax_r, dyay_r, dxay_r, dyax_r;
  logic [PW-1:0]        sqax_r, sqay_r, sqbx_r, sqby_r, sqdx_r, sqdy_r;

  // Sum stage
  lsht_pkg::ctl_t       ctl_c_r;
  logic signed [SW-1:0] dot_r, cp_r;
  logic [QW-1:0]        near_r, far_r, d2_r;

  assign sx = cfg.start_x;
  assign sy = cfg.start_y;
  assign ex = cfg.end_x;
  assign ey = cfg.end_y;
  assign dx = {ex[CW-1], ex} - {sx[CW-1], sx};
  assign dy = {ey[CW-1], ey} - {sy[CW-1], sy};

  // Form every product in parallel
  assign dxax_nxt = dx * ax;
  assign dyay_nxt = dy * ay;
  assign dxay_nxt = dx * ay;
  assign dyax_nxt = dy * ax;
  assign sqax_nxt = ax * ax;
  assign sqay_nxt = ay * ay;
  assign sqbx_nxt = bx * bx;
  assign sqby_nxt = by * by;
  assign sqdx_nxt = dx * dx;
  assign sqdy_nxt = dy * dy;

  // Advance the valid bits; register products, then the sums built from them
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_b_r.valid <= 1'b0;
      ctl_c_r.valid <= 1'b0;
    end else begin
      ctl_b_r.valid <= ctl_i.valid;
      ctl_c_r.valid <= ctl_b_r.valid;
    end

    ctl_b_r.mode     <= ctl_i.mode;
    ctl_b_r.rect_hit <= ctl_i.rect_hit;
    dxax_r           <= dxax_nxt;
    dyay_r           <= dyay_nxt;
    dxay_r           <= dxay_nxt;
    dyax_r           <= dyax_nxt;
    sqax_r           <= sqax_nxt;
    sqay_r           <= sqay_nxt;
    sqbx_r           <= sqbx_nxt;
    sqby_r           <= sqby_nxt;
    sqdx_r           <= sqdx_nxt;
    sqdy_r           <= sqdy_nxt;

    ctl_c_r.mode     <= ctl_b_r.mode;
    ctl_c_r.rect_hit <= ctl_b_r.rect_hit;
    dot_r            <= {dxax_r[PW-1], dxax_r} + {dyay_r[PW-1], dyay_r};
    cp_r             <= {dxay_r[PW-1], dxay_r} - {dyax_r[PW-1], dyax_r};
    near_r           <= QW'(sqax_r) + QW'(sqay_r);
    far_r            <= QW'(sqbx_r) + QW'(sqby_r);
    d2_r             <= QW'(sqdx_r) + QW'(sqdy_r);
  end

  assign ctl_o   = ctl_c_r;
  assign dot     = dot_r;
  assign cp      = cp_r;
  assign near_sq = near_r;
  assign far_sq  = far_r;
  assign d2      = d2_r;

endmodule

`default_nettype wire

// ----- rtl/lsht_decide.sv -----
// Last four pipeline stages: region choice, squaring of the cross product in
// split halves, recombination and the final compare into the output register.
// Depends on lsht_pkg.
`default_nettype none

module lsht_decide (
  input  wire logic                                  clk,
  input  wire logic                                  rst_n,
  input  wire lsht_pkg::ctl_t                        ctl_i,
  input  wire logic signed [lsht_pkg::SUM_WIDTH-1:0] dot,
  input  wire logic signed [lsht_pkg::SUM_WIDTH-1:0] cp,
  input  wire logic [lsht_pkg::SQ_WIDTH-1:0]         near_sq,
  input  wire logic [lsht_pkg::SQ_WIDTH-1:0]         far_sq,
  input  wire logic [lsht_pkg::SQ_WIDTH-1:0]         d2,
  input  wire logic [lsht_pkg::LW_WIDTH-1:0]         line_width,
  output logic                                       out_valid,
  output lsht_pkg::out_t                             out_data
);

  localparam int SW  = lsht_pkg::SUM_WIDTH;
  localparam int QW  = lsht_pkg::SQ_WIDTH;
  localparam int HW  = lsht_pkg::HALF_WIDTH;
  localparam int W2W = lsht_pkg::W2_WIDTH;
  localparam int MW  = lsht_pkg::CMP_WIDTH;
  localparam int RGW = lsht_pkg::REGION_WIDTH;

  // Region stage
  logic [RGW-1:0]       region_nxt;
  logic signed [SW-1:0] cp_abs;
  logic                 d_valid_r;
  logic                 d_rect_r;
  logic [RGW-1:0]       d_region_r;
  logic [QW-1:0]        d_mag_r, d_pt_r, d_d2_r;
  logic [W2W-1:0]       d_w2_r;

  // Partial product stage
  logic                 e_valid_r;
  logic                 e_pre_r;
  logic [RGW-1:0]       e_region_r;
  logic [2*HW-1:0]      e_hh_r, e_hl_r, e_ll_r;
  logic [W2W+HW-1:0]    e_wdh_r, e_wdl_r;
  logic                 pre_nxt;

  // Recombine stage
  logic                 f_valid_r;
  logic                 f_pre_r;
  logic [RGW-1:0]       f_region_r;
  logic [MW-1:0]        f_cp2_r, f_wd2_r;

  // Output stage
  logic                 inner_hit;
  logic                 out_valid_r;
  lsht_pkg::out_t       out_r;

  // Choose the region from the shape and where the point projects
  always_comb begin
    unique case (ctl_i.mode)
      lsht_pkg::MODE_HORZ: region_nxt = lsht_pkg::REGION_HORZ;
      lsht_pkg::MODE_VERT: region_nxt = lsht_pkg::REGION_VERT;
      lsht_pkg::MODE_DIST: begin
        priority if (dot[SW-1] || (dot == '0)) begin
          region_nxt = lsht_pkg::REGION_START;
        end else if (dot >= $signed({1'b0, d2})) begin
          region_nxt = lsht_pkg::REGION_END;
        end else begin
          region_nxt = lsht_pkg::REGION_INTERIOR;
        end
      end
      default: region_nxt = lsht_pkg::REGION_HORZ;
    endcase
  end

  assign cp_abs = cp[SW-1] ? -cp : cp;

  // Decide the endpoint and rectangle cases from the region stage
  always_comb begin
    if (d_region_r == lsht_pkg::REGION_HORZ || d_region_r == lsht_pkg::REGION_VERT) begin
      pre_nxt = d_rect_r;
    end else begin
      pre_nxt = ({d_pt_r, 2'b00} <= (QW + 2)'(d_w2_r));
    end
  end

  // Compare four times the squared cross product with w^2 * d2
  assign inner_hit = ((f_cp2_r << 2) <= f_wd2_r);

  // Advance all valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      d_valid_r   <= 1'b0;
      e_valid_r   <= 1'b0;
      f_valid_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      d_valid_r   <= ctl_i.valid;
      e_valid_r   <= d_valid_r;
      f_valid_r   <= e_valid_r;
      out_valid_r <= f_valid_r;
    end
  end

  // Move the payload down the four stages
  always_ff @(posedge clk) begin
    d_rect_r   <= ctl_i.rect_hit;
    d_region_r <= region_nxt;
    d_mag_r    <= cp_abs[QW-1:0];
    d_pt_r     <= (region_nxt == lsht_pkg::REGION_START) ? near_sq : far_sq;
    d_d2_r     <= d2;
    d_w2_r     <= line_width * line_width;

    e_pre_r    <= pre_nxt;
    e_region_r <= d_region_r;
    e_hh_r     <= d_mag_r[QW-1:HW] * d_mag_r[QW-1:HW];
    e_hl_r     <= d_mag_r[QW-1:HW] * d_mag_r[HW-1:0];
    e_ll_r     <= d_mag_r[HW-1:0] * d_mag_r[HW-1:0];
    e_wdh_r    <= d_w2_r * d_d2_r[QW-1:HW];
    e_wdl_r    <= d_w2_r * d_d2_r[HW-1:0];

    f_pre_r    <= e_pre_r;
    f_region_r <= e_region_r;
    f_cp2_r    <= (MW'(e_hh_r) << (2 * HW)) + (MW'(e_hl_r) << (HW + 1)) + MW'(e_ll_r);
    f_wd2_r    <= (MW'(e_wdh_r) << HW) + MW'(e_wdl_r);

    out_r.region <= f_region_r;
    out_r.hit    <= (f_region_r == lsht_pkg::REGION_INTERIOR) ? inner_hit : f_pre_r;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

`default_nettype wire

// ----- rtl/line_segment_hit_test.sv -----
// Thick line segment hit test: one query point per clock, result strobed on
// out_valid for each cycle in which start is sampled high. Throughput is one
// transaction per cycle; busy stays low, and the result holds for one cycle
// only. The pipeline has seven register stages: offsets, products, sums,
// region, split squaring, recombine, compare. Synchronous reset clears the
// pipeline and loads endpoints 0 and line width 80 (5.0 px).
`default_nettype none

module line_segment_hit_test (
  input  wire logic                                  clk,
  input  wire logic                                  rst_n,
  input  wire logic                                  start,
  output logic                                       busy,
  input  wire lsht_pkg::in_t                         in_data,
  output logic                                       out_valid,
  output lsht_pkg::out_t                             out_data,
  input  wire logic                                  cfg_we,
  input  wire logic [lsht_pkg::CFG_IDX_WIDTH-1:0]    cfg_idx,
  input  wire logic [lsht_pkg::COORD_WIDTH-1:0]      cfg_wdata
);

  localparam int CW = lsht_pkg::COORD_WIDTH;
  localparam int DW = lsht_pkg::DIFF_WIDTH;
  localparam int SW = lsht_pkg::SUM_WIDTH;
  localparam int QW = lsht_pkg::SQ_WIDTH;

  logic signed [CW-1:0]              start_x_r, start_y_r, end_x_r, end_y_r;
  logic [lsht_pkg::LW_WIDTH-1:0]     line_width_r;
  lsht_pkg::cfg_t                    cfg;
  logic                              accept;

  lsht_pkg::ctl_t                    ctl_a, ctl_c;
  logic signed [DW-1:0]              ax, ay, bx, by;
  logic signed [SW-1:0]              dot, cp;
  logic [QW-1:0]                     near_sq, far_sq, d2;

  // Pipeline takes a transaction every cycle
  assign busy   = 1'b0;
  assign accept = start && !busy;

  // Write configuration registers; unknown indexes are dropped
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_x_r    <= '0;
      start_y_r    <= '0;
      end_x_r      <= '0;
      end_y_r      <= '0;
      line_width_r <= lsht_pkg::LINE_WIDTH_RST;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        lsht_pkg::CFG_START_X:    start_x_r    <= cfg_wdata;
        lsht_pkg::CFG_START_Y:    start_y_r    <= cfg_wdata;
        lsht_pkg::CFG_END_X:      end_x_r      <= cfg_wdata;
        lsht_pkg::CFG_END_Y:      end_y_r      <= cfg_wdata;
        lsht_pkg::CFG_LINE_WIDTH: line_width_r <= cfg_wdata[lsht_pkg::LW_WIDTH-1:0];
        default: ;
      endcase
    end
  end

  assign cfg = '{start_x:    start_x_r,
                 start_y:    start_y_r,
                 end_x:      end_x_r,
                 end_y:      end_y_r,
                 line_width: line_width_r};

  lsht_diff u_diff (
    .clk     (clk),
    .rst_n   (rst_n),
    .accept  (accept),
    .in_data (in_data),
    .cfg     (cfg),
    .ctl     (ctl_a),
    .ax      (ax),
    .ay      (ay),
    .bx      (bx),
    .by      (by)
  );

  lsht_mult u_mult (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctl_i   (ctl_a),
    .ax      (ax),
    .ay      (ay),
    .bx      (bx),
    .by      (by),
    .cfg     (cfg),
    .ctl_o   (ctl_c),
    .dot     (dot),
    .cp      (cp),
    .near_sq (near_sq),
    .far_sq  (far_sq),
    .d2      (d2)
  );

  lsht_decide u_decide (
    .clk        (clk),
    .rst_n      (rst_n),
    .ctl_i      (ctl_c),
    .dot        (dot),
    .cp         (cp),
    .near_sq    (near_sq),
    .far_sq     (far_sq),
    .d2         (d2),
    .line_width (line_width_r),
    .out_valid  (out_valid),
    .out_data   (out_data)
  );

`ifndef NO_ASSERTIONS
  // Every result traces back to an accepted transaction
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(accept, 7))
    else $error("result without a matching transaction");

  // Region codes stay within the defined set
  a_region: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.region <= lsht_pkg::REGION_INTERIOR))
    else $error("region code out of range");

  // Horizontal results only come from endpoints with a shared y
  a_horz: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_data.region == lsht_pkg::REGION_HORZ)) |-> (start_y_r == end_y_r))
    else $error("horizontal region with differing endpoint y");

  // A zero-width rectangle never reports a hit
  a_zero_width: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (line_width_r == '0) &&
     ((out_data.region == lsht_pkg::REGION_HORZ) ||
      (out_data.region == lsht_pkg::REGION_VERT))) |-> !out_data.hit)
    else $error("hit reported on zero-width rectangle");
`endif

endmodule

`default_nettype wire

// ----- tb/line_segment_hit_test_tb.sv -----
// Self-checking testbench for line_segment_hit_test: directed probes, then random segments
// and query points in bursts. Hit/region: per-probe answer or in-bench distance predictor.
// Depends on lsht_pkg and the line_segment_hit_test top level only.
`default_nettype none

module line_segment_hit_test_tb;

  localparam int CW          = lsht_pkg::COORD_WIDTH;
  localparam int LWW         = lsht_pkg::LW_WIDTH;
  localparam int RGW         = lsht_pkg::REGION_WIDTH;
  localparam int IW          = lsht_pkg::CFG_IDX_WIDTH;
  localparam int LATENCY     = 7;
  localparam int CYCLE_LIMIT = 200000;
  localparam int NUM_PHASES  = 15;
  localparam int PHASE_ITEMS = 100;
  localparam bit PRED        = 1'b0;
  localparam bit TYPED       = 1'b1;

  typedef logic [127:0] mag_t;

  // One directed probe: segment setting as raw write data, query point, optional answer
  typedef struct {
    logic [CW-1:0]  sx, sy, ex, ey, lw;
    logic [CW-1:0]  px, py;
    bit             known;
    bit             hit;
    logic [RGW-1:0] region;
  } probe_t;

  logic                clk       = 1'b0;
  logic                rst_n     = 1'b0;
  logic                start     = 1'b0;
  logic                busy;
  lsht_pkg::in_t       in_data   = '0;
  logic                out_valid;
  lsht_pkg::out_t      out_data;
  logic                cfg_we    = 1'b0;
  logic [IW-1:0]       cfg_idx   = '0;
  logic [CW-1:0]       cfg_wdata = '0;

  // Bench copy of the segment registers
  logic signed [CW-1:0] seg_sx = '0, seg_sy = '0, seg_ex = '0, seg_ey = '0;
  logic [LWW-1:0]       seg_lw = lsht_pkg::LINE_WIDTH_RST;

  logic [IW-1:0] reg_ids [5] = '{lsht_pkg::CFG_START_X, lsht_pkg::CFG_START_Y,
                                 lsht_pkg::CFG_END_X, lsht_pkg::CFG_END_Y,
                                 lsht_pkg::CFG_LINE_WIDTH};

  lsht_pkg::out_t pending_q [$];
  int   n_checked       = 0;
  int   n_bad           = 0;
  int   n_fail          = 0;
  int   n_hits          = 0;
  int   region_seen [5] = '{default: 0};
  int   segments_loaded = 0;
  int   cycle_count     = 0;
  int   burst_left      = 0;

  line_segment_hit_test u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Abort a hung run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycle_count,
               pending_q.size());
      $display("FAILURE");
      $finish;
    end
  end

  // Open rectangle test in doubled units, so that half the width stays exact
  function automatic bit in_open_box(bit fwd, longint x2, longint y2, longint w);
    longint sx2, sy2, ex2, ey2;
    sx2 = 2 * longint'(seg_sx);
    sy2 = 2 * longint'(seg_sy);
    ex2 = 2 * longint'(seg_ex);
    ey2 = 2 * longint'(seg_ey);
    if (fwd)
      return x2 > sx2 - w && y2 > sy2 - w && x2 < ex2 + w && y2 < ey2 + w;
    return x2 < sx2 + w && y2 < sy2 + w && x2 > ex2 - w && y2 > ey2 - w;
  endfunction

  // Expected hit and region for one query point against the current segment
  function automatic lsht_pkg::out_t predict_hit(lsht_pkg::in_t p);
    longint         px, py, dx, dy, ax, ay, bx, by, dot, d2, cp, w;
    mag_t           lhs, rhs, cm;
    lsht_pkg::out_t r;
    px = longint'(p.point_x);
    py = longint'(p.point_y);
    w  = longint'(seg_lw);
    if (seg_sy == seg_ey) begin
      r.region = lsht_pkg::REGION_HORZ;
      r.hit    = in_open_box(seg_sx < seg_ex, 2 * px, 2 * py, w);
    end else if (seg_sx == seg_ex) begin
      r.region = lsht_pkg::REGION_VERT;
      r.hit    = in_open_box(seg_sy < seg_ey, 2 * px, 2 * py, w);
    end else begin
      dx  = longint'(seg_ex) - longint'(seg_sx);
      dy  = longint'(seg_ey) - longint'(seg_sy);
      ax  = px - longint'(seg_sx);
      ay  = py - longint'(seg_sy);
      dot = dx * ax + dy * ay;
      d2  = dx * dx + dy * dy;
      if (dot <= 0) begin
        r.region = lsht_pkg::REGION_START;
        lhs      = mag_t'(4 * (ax * ax + ay * ay));
        rhs      = mag_t'(w * w);
      end else if (dot >= d2) begin
        bx       = px - longint'(seg_ex);
        by       = py - longint'(seg_ey);
        r.region = lsht_pkg::REGION_END;
        lhs      = mag_t'(4 * (bx * bx + by * by));
        rhs      = mag_t'(w * w);
      end else begin
        cp       = dx * ay - dy * ax;
        cm       = mag_t'(cp < 0 ? -cp : cp);
        r.region = lsht_pkg::REGION_INTERIOR;
        lhs      = 4 * cm * cm;
        rhs      = mag_t'(w * w) * mag_t'(d2);
      end
      r.hit = (lhs <= rhs);
    end
    return r;
  endfunction

  // Mirror one register write; unused indexes change nothing
  function automatic void apply_reg(logic [IW-1:0] idx, logic [CW-1:0] v);
    case (idx)
      lsht_pkg::CFG_START_X:    seg_sx = v;
      lsht_pkg::CFG_START_Y:    seg_sy = v;
      lsht_pkg::CFG_END_X:      seg_ex = v;
      lsht_pkg::CFG_END_Y:      seg_ey = v;
      lsht_pkg::CFG_LINE_WIDTH: seg_lw = v[LWW-1:0];
      default: ;
    endcase
  endfunction

  function automatic probe_t mk(int sx, int sy, int ex, int ey, int lw, int px, int py,
                                bit known, bit hit, logic [RGW-1:0] region);
    probe_t r;
    r.sx     = sx[CW-1:0];
    r.sy     = sy[CW-1:0];
    r.ex     = ex[CW-1:0];
    r.ey     = ey[CW-1:0];
    r.lw     = lw[CW-1:0];
    r.px     = px[CW-1:0];
    r.py     = py[CW-1:0];
    r.known  = known;
    r.hit    = hit;
    r.region = region;
    return r;
  endfunction

  function automatic logic [CW-1:0] rand_coord();
    if ($urandom_range(0, 3) == 0)
      return CW'($urandom);
    return CW'(int'($urandom_range(0, 4000)) - 2000);
  endfunction

  // Query point: along the segment, near either end, or anywhere
  function automatic lsht_pkg::in_t near_point(int mode);
    int            t, spread, x, y;
    lsht_pkg::in_t p;
    spread = int'(seg_lw) / 2 + 4;
    case (mode)
      0: begin
        t = int'($urandom_range(0, 384)) - 64;
        x = int'(seg_sx) + ((int'(seg_ex) - int'(seg_sx)) * t) / 256;
        y = int'(seg_sy) + ((int'(seg_ey) - int'(seg_sy)) * t) / 256;
      end
      1: begin
        x = int'(seg_sx);
        y = int'(seg_sy);
      end
      2: begin
        x = int'(seg_ex);
        y = int'(seg_ey);
      end
      default: begin
        x = int'($urandom);
        y = int'($urandom);
      end
    endcase
    if (mode != 3) begin
      x = x + int'($urandom_range(0, 2 * spread)) - spread;
      y = y + int'($urandom_range(0, 2 * spread)) - spread;
    end
    p.point_x = x[CW-1:0];
    p.point_y = y[CW-1:0];
    return p;
  endfunction

  task automatic write_reg(logic [IW-1:0] idx, logic [CW-1:0] v);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= v;
    apply_reg(idx, v);
    @(posedge clk);
  endtask

  // Write all five registers in a rotated order, optionally poking an unused index
  task automatic load_segment(logic [CW-1:0] sx, sy, ex, ey, lw, bit poke_unused);
    logic [CW-1:0] vals [5];
    int            first;
    vals  = '{sx, sy, ex, ey, lw};
    first = $urandom_range(0, 4);
    for (int k = 0; k < 5; k++) begin
      if (poke_unused && k == 2)
        write_reg(lsht_pkg::CFG_LINE_WIDTH + IW'($urandom_range(1, 3)), CW'($urandom));
      write_reg(reg_ids[(first + k) % 5], vals[(first + k) % 5]);
    end
    cfg_we <= 1'b0;
    segments_loaded++;
  endtask

  // Hold off new transactions until every expected result is back
  task automatic drain_results();
    start      <= 1'b0;
    burst_left  = 0;
    while (pending_q.size() != 0) @(posedge clk);
  endtask

  // Send one transaction; open a new burst with a random gap when the last one is used up
  task automatic issue_point(lsht_pkg::in_t p, bit known, lsht_pkg::out_t want);
    int gap;
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 9) == 0) ? 80 : $urandom_range(1, 24);
      gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap != 0) begin
        start <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    in_data <= p;
    start   <= 1'b1;
    @(posedge clk);
    while (busy) @(posedge clk);
    pending_q.push_back(known ? want : predict_hit(p));
    burst_left--;
  endtask

  // Pick a segment shape and width for one random phase; the first three are extremes
  task automatic pick_segment(int ph);
    logic [CW-1:0] sx, sy, ex, ey, lw;
    int            kind;
    case (ph)
      0: begin
        sx = 16'h8000; sy = 16'h8000; ex = 16'h7fff; ey = 16'h7fff; lw = 16'h0fff;
      end
      1: begin
        sx = 16'h7fff; sy = 16'h8000; ex = 16'h8000; ey = 16'h7fff; lw = 16'h0000;
      end
      2: begin
        sx = 16'h8000; sy = 16'h7fff; ex = 16'h7fff; ey = 16'h7fff; lw = 16'hffff;
      end
      default: begin
        kind = $urandom_range(0, 9);
        sx   = rand_coord();
        sy   = rand_coord();
        ex   = rand_coord();
        ey   = rand_coord();
        case (kind)
          0, 1:    ey = sy;
          2, 3:    ex = sx;
          4: begin
            ex = sx;
            ey = sy;
          end
          default: begin
            if (ex == sx) ex = ex + 1'b1;
            if (ey == sy) ey = ey + 1'b1;
          end
        endcase
        case ($urandom_range(0, 7))
          0:       lw = '0;
          1:       lw = 16'h0fff;
          2, 3, 4: lw = CW'($urandom_range(1, 200));
          default: lw = CW'($urandom_range(0, 4095));
        endcase
        // random upper bits must be ignored by the width register
        lw[CW-1:LWW] = 4'($urandom);
      end
    endcase
    load_segment(sx, sy, ex, ey, lw, ph == 0 || $urandom_range(0, 1) == 1);
  endtask

  // Compare each strobed result against the oldest expectation
  always @(posedge clk) begin : check_results
    lsht_pkg::out_t want;
    if (rst_n && out_valid) begin
      if (pending_q.size() == 0) begin
        n_fail++;
        if (n_bad < 10)
          $display("unexpected result: hit %0b region %0d", out_data.hit, out_data.region);
        n_bad++;
      end else begin
        want = pending_q.pop_front();
        n_checked++;
        if (out_data.hit !== want.hit || out_data.region !== want.region) begin
          n_fail++;
          if (n_bad < 10)
            $display("mismatch at result %0d: hit exp %0b got %0b, region exp %0d got %0d",
                     n_checked, want.hit, out_data.hit, want.region, out_data.region);
          n_bad++;
        end else begin
          if (out_data.hit) n_hits++;
          if (out_data.region <= lsht_pkg::REGION_INTERIOR) region_seen[out_data.region]++;
        end
      end
    end
  end

  initial begin : stimulus
    probe_t         probes [$];
    probe_t         last, pr;
    lsht_pkg::in_t  p;
    lsht_pkg::out_t want;
    int             r;

    // Reset values: coincident endpoints at the origin, width 5 px (open square)
    probes.push_back(mk(0, 0, 0, 0, 80, 0, 0, TYPED, 1, lsht_pkg::REGION_HORZ));
    probes.push_back(mk(0, 0, 0, 0, 80, 39, -39, TYPED, 1, lsht_pkg::REGION_HORZ));
    probes.push_back(mk(0, 0, 0, 0, 80, 40, 0, TYPED, 0, lsht_pkg::REGION_HORZ));
    probes.push_back(mk(0, 0, 0, 0, 80, -32768, 32767, TYPED, 0, lsht_pkg::REGION_HORZ));
    probes.push_back(mk(0, 0, 0, 0, 80, 32767, -32768, TYPED, 0, lsht_pkg::REGION_HORZ));
    // Horizontal, strict bounds on the far end and on the side
    probes.push_back(mk(-100, 0, 100, 0, 80, 139, 0, TYPED, 1, lsht_pkg::REGION_HORZ));
    probes.push_back(mk(-100, 0, 100, 0, 80, 140, 0, TYPED, 0, lsht_pkg::REGION_HORZ));
    probes.push_back(mk(-100, 0, 100, 0, 80, 0, 40, TYPED, 0, lsht_pkg::REGION_HORZ));
    // Reversed horizontal with zero width never hits
    probes.push_back(mk(100, 5, -100, 5, 0, 0, 5, TYPED, 0, lsht_pkg::REGION_HORZ));
    // Vertical, width written with junk above bit 11
    probes.push_back(mk(0, -100, 0, 100, 'hf050, 0, 0, TYPED, 1, lsht_pkg::REGION_VERT));
    probes.push_back(mk(0, -100, 0, 100, 'hf050, 40, 0, TYPED, 0, lsht_pkg::REGION_VERT));
    probes.push_back(mk(0, 100, 0, -100, 80, 0, 139, TYPED, 1, lsht_pkg::REGION_VERT));
    // Diagonal: before start, on start, on end, interior, off to the side
    probes.push_back(mk(0, 0, 100, 100, 80, -10, -10, TYPED, 1, lsht_pkg::REGION_START));
    probes.push_back(mk(0, 0, 100, 100, 80, 0, 0, TYPED, 1, lsht_pkg::REGION_START));
    probes.push_back(mk(0, 0, 100, 100, 80, 100, 100, TYPED, 1, lsht_pkg::REGION_END));
    probes.push_back(mk(0, 0, 100, 100, 80, 50, 50, TYPED, 1, lsht_pkg::REGION_INTERIOR));
    probes.push_back(mk(0, 0, 100, 100, 80, 50, -50, TYPED, 0, lsht_pkg::REGION_START));
    probes.push_back(mk(0, 0, 100, 100, 80, 60, 40, PRED, 0, lsht_pkg::REGION_HORZ));
    // Zero width diagonal hits only points exactly on the segment
    probes.push_back(mk(0, 0, 100, 100, 0, 50, 50, TYPED, 1, lsht_pkg::REGION_INTERIOR));
    probes.push_back(mk(0, 0, 100, 100, 0, 51, 50, TYPED, 0, lsht_pkg::REGION_INTERIOR));
    // Full-range diagonals with the widest line
    probes.push_back(mk(-32768, -32768, 32767, 32767, 4095, 32767, -32768, PRED, 0,
                        lsht_pkg::REGION_HORZ));
    probes.push_back(mk(-32768, -32768, 32767, 32767, 4095, -32768, 32767, PRED, 0,
                        lsht_pkg::REGION_HORZ));
    probes.push_back(mk(-32768, -32768, 32767, 32767, 4095, 0, 0, PRED, 0,
                        lsht_pkg::REGION_HORZ));
    probes.push_back(mk(32767, -32768, -32768, 32767, 'hffff, 0, 0, PRED, 0,
                        lsht_pkg::REGION_HORZ));
    probes.push_back(mk(32767, -32768, -32768, 32767, 'hffff, -32768, -32768, PRED, 0,
                        lsht_pkg::REGION_HORZ));

    last = mk(0, 0, 0, 0, 80, 0, 0, PRED, 0, lsht_pkg::REGION_HORZ);

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed probes; reload the segment only when a row changes it
    foreach (probes[i]) begin
      pr = probes[i];
      if (pr.sx != last.sx || pr.sy != last.sy || pr.ex != last.ex || pr.ey != last.ey ||
          pr.lw != last.lw) begin
        drain_results();
        load_segment(pr.sx, pr.sy, pr.ex, pr.ey, pr.lw, 1'b0);
        last = pr;
      end
      p.point_x   = pr.px;
      p.point_y   = pr.py;
      want.hit    = pr.hit;
      want.region = pr.region;
      issue_point(p, pr.known, want);
    end

    // Random phases: one segment each, points mostly close to it
    want = '0;
    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      drain_results();
      pick_segment(ph);
      for (int k = 0; k < PHASE_ITEMS; k++) begin
        if (ph == 4 && k == PHASE_ITEMS / 2) drain_results();
        r = $urandom_range(0, 19);
        p = near_point(r < 10 ? 0 : r < 14 ? 1 : r < 17 ? 2 : 3);
        issue_point(p, PRED, want);
      end
    end

    // Wait out the pipeline, then catch any stray strobes
    start <= 1'b0;
    while (pending_q.size() != 0) @(posedge clk);
    repeat (LATENCY + 3) @(posedge clk);
    if (pending_q.size() != 0) begin
      $display("%0d expected results never arrived", pending_q.size());
      n_fail++;
    end

    $display("checked %0d hit tests over %0d segment settings, %0d mismatches",
             n_checked, segments_loaded, n_bad);
    $display("hits %0d; regions horz/vert/start/end/interior %0d/%0d/%0d/%0d/%0d", n_hits,
             region_seen[0], region_seen[1], region_seen[2], region_seen[3], region_seen[4]);
    if (n_fail == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

`default_nettype wire

// ----- filelist.f -----
rtl/lsht_pkg.sv
rtl/lsht_diff.sv
rtl/lsht_mult.sv
rtl/lsht_decide.sv
rtl/line_segment_hit_test.sv
tb/line_segment_hit_test_tb.sv
